// ===== design/lum_pkg.sv =====
// ----------------------------------------------------------------------------
// lum_pkg
// Shared types and constants of the link utilization meter.
// ----------------------------------------------------------------------------
`default_nettype none

package lum_pkg;

	localparam int unsigned CNT_W   = 32;
	localparam int unsigned PROD_W  = 64;
	localparam int unsigned ITER_W  = 7;
	localparam int unsigned PMIL_W  = 10;

	localparam logic [CNT_W-1:0] TPS_RESET = 32'd100000000;

	localparam int unsigned MBIT_SCALE     = 1000000;
	localparam int unsigned BITS_PER_OCTET = 8;

	localparam logic [PMIL_W-1:0] PMIL_FULL  = 10'd1000;
	localparam logic [PMIL_W-1:0] LINE_GIGE  = 10'd1000;
	localparam logic [PMIL_W-1:0] LINE_FAST  = 10'd100;
	localparam logic [PMIL_W-1:0] LINE_SLOW  = 10'd10;

	localparam logic [CNT_W-1:0] CAP_GIGE = 32'(1000 * MBIT_SCALE / BITS_PER_OCTET);
	localparam logic [CNT_W-1:0] CAP_FAST = 32'(100 * MBIT_SCALE / BITS_PER_OCTET);
	localparam logic [CNT_W-1:0] CAP_SLOW = 32'(10 * MBIT_SCALE / BITS_PER_OCTET);

	localparam logic [ITER_W-1:0] ITER_RATE = 7'd64;
	localparam logic [ITER_W-1:0] ITER_PMIL = 7'd10;

	localparam logic [1:0] CFG_PORT_SELECT = 2'd0;
	localparam logic [1:0] CFG_FAST_SELECT = 2'd1;
	localparam logic [1:0] CFG_TPS         = 2'd2;

	typedef struct packed {
		logic              start;
		logic [ITER_W-1:0] count;
		logic [CNT_W-1:0]  rem;
		logic [PROD_W-1:0] num;
		logic [CNT_W-1:0]  den;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [PROD_W-1:0] quo;
	} div_rsp_t;

endpackage

`default_nettype wire

// ===== design/lum_divider.sv =====
// ----------------------------------------------------------------------------
// lum_divider
// Restoring divider, one quotient bit per cycle, with a loadable partial
// remainder and iteration count.
// ----------------------------------------------------------------------------
`default_nettype none

module lum_divider
	import lum_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	logic              busy_q;
	logic              done_q;
	logic [ITER_W-1:0] cnt_q;
	logic [CNT_W-1:0]  rem_q;
	logic [PROD_W-1:0] num_q;
	logic [CNT_W-1:0]  den_q;

	logic [CNT_W:0] rem_sh;
	logic [CNT_W:0] diff;
	logic           ge;

	assign rem_sh = {rem_q, num_q[PROD_W-1]};
	assign diff   = rem_sh - {1'b0, den_q};
	assign ge     = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.count;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.rem;
			num_q <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
			num_q <= {num_q[PROD_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = num_q;

endmodule

`default_nettype wire

// ===== design/link_utilization_meter_core.sv =====
// ----------------------------------------------------------------------------
// link_utilization_meter_core
// Windowed throughput and utilization meter over free-running counters.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake            Payload
// s_*      in   s_tvalid/s_tready    tdata: now_ticks, tx_octets, rx_octets
//                                    tuser: command
// m_*      out  m_tvalid/m_tready    tdata: bytes_per_second, utilisation_pmil,
//                                    link_mbits; tuser: window_closed
// cfg_*    in   cfg_we               cfg_index, cfg_data
//
// A restart or an update inside an open window goes via S_DONE to the output
// register. An update that closes a window uses at most a pass of the shared
// 32x32 multiplier, 64 iterations of the shared divider for the rate, a second
// multiplier pass and 10 divider iterations for the per mille value. s_tready
// is high only in the idle state, so an input may be taken while a result waits
// on m_tready. Reset clears all window state and loads the default tick rate.
// ----------------------------------------------------------------------------
`default_nettype none

module link_utilization_meter_core
	import lum_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [95:0] s_tdata,   // now_ticks[31:0], tx_octets[63:32], rx_octets[95:64]
	input  wire logic [0:0]  s_tuser,   // command[0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [55:0]      m_tdata,   // bytes_per_second[31:0], utilisation_pmil[41:32],
	                                    // link_mbits[51:42], zero[55:52]
	output logic [0:0]       m_tuser,   // window_closed[0]
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL,
		S_D1GO,
		S_D1WAIT,
		S_SCALE,
		S_D2GO,
		S_D2WAIT,
		S_DONE
	} state_t;

	state_t state_q;

	logic             port_sel_q;
	logic             fast_sel_q;
	logic [CNT_W-1:0] tps_q;

	logic [CNT_W-1:0]  win_start_q;
	logic [CNT_W-1:0]  tx_base_q;
	logic [CNT_W-1:0]  rx_base_q;
	logic [CNT_W-1:0]  rate_q;
	logic [PMIL_W-1:0] util_q;
	logic              closed_q;

	logic [CNT_W-1:0]  now_q;
	logic [CNT_W-1:0]  tx_q;
	logic [CNT_W-1:0]  rx_q;
	logic [CNT_W-1:0]  elapsed_q;
	logic [CNT_W-1:0]  delta_q;
	logic [PROD_W-1:0] prod_q;

	logic              out_valid_q;
	logic [CNT_W-1:0]  out_rate_q;
	logic [PMIL_W-1:0] out_util_q;
	logic [PMIL_W-1:0] out_mbits_q;
	logic              out_closed_q;

	logic              cmd;
	logic [CNT_W-1:0]  now_in;
	logic [CNT_W-1:0]  tx_in;
	logic [CNT_W-1:0]  rx_in;
	logic [CNT_W-1:0]  elapsed;
	logic [CNT_W-1:0]  delta;
	logic [PMIL_W-1:0] mbits;
	logic [CNT_W-1:0]  cap;
	logic [CNT_W-1:0]  mul_a;
	logic [CNT_W-1:0]  mul_b;
	logic [PROD_W-1:0] mul_p;
	logic              accept;

	div_req_t div_req;
	div_rsp_t div_rsp;

	assign cmd     = s_tuser[0];
	assign now_in  = s_tdata[31:0];
	assign tx_in   = s_tdata[63:32];
	assign rx_in   = s_tdata[95:64];
	assign elapsed = now_in - win_start_q;
	assign delta   = (tx_in - tx_base_q) + (rx_in - rx_base_q);

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		priority if (!port_sel_q) begin
			mbits = LINE_GIGE;
			cap   = CAP_GIGE;
		end else if (fast_sel_q) begin
			mbits = LINE_FAST;
			cap   = CAP_FAST;
		end else begin
			mbits = LINE_SLOW;
			cap   = CAP_SLOW;
		end
	end

	// shared multiplier
	assign mul_a = (state_q == S_MUL) ? delta_q : rate_q;
	assign mul_b = (state_q == S_MUL) ? tps_q : {22'd0, PMIL_FULL};
	assign mul_p = 64'(mul_a) * 64'(mul_b);

	always_comb begin
		div_req.start = (state_q == S_D1GO) || (state_q == S_D2GO);
		if (state_q == S_D1GO) begin
			div_req.count = ITER_RATE;
			div_req.rem   = '0;
			div_req.num   = prod_q;
			div_req.den   = elapsed_q;
		end else begin
			div_req.count = ITER_PMIL;
			div_req.rem   = prod_q[41:10];
			div_req.num   = {prod_q[9:0], 54'd0};
			div_req.den   = cap;
		end
	end

	lum_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port_sel_q <= 1'b0;
			fast_sel_q <= 1'b0;
			tps_q      <= TPS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PORT_SELECT: port_sel_q <= cfg_data[0];
				CFG_FAST_SELECT: fast_sel_q <= cfg_data[0];
				CFG_TPS:         tps_q      <= cfg_data;
				default:         ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			win_start_q  <= '0;
			tx_base_q    <= '0;
			rx_base_q    <= '0;
			rate_q       <= '0;
			util_q       <= '0;
			closed_q     <= 1'b0;
			out_valid_q  <= 1'b0;
			out_rate_q   <= '0;
			out_util_q   <= '0;
			out_mbits_q  <= '0;
			out_closed_q <= 1'b0;
		end else begin
			if (out_valid_q && m_tready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						closed_q <= 1'b0;
						if (cmd) begin
							win_start_q <= now_in;
							tx_base_q   <= '0;
							rx_base_q   <= '0;
							rate_q      <= '0;
							util_q      <= '0;
							state_q     <= S_DONE;
						end else if (elapsed >= tps_q) begin
							state_q <= S_MUL;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_MUL: begin
					if (elapsed_q == '0) begin
						rate_q  <= '0;
						state_q <= S_SCALE;
					end else begin
						state_q <= S_D1GO;
					end
				end
				S_D1GO: begin
					state_q <= S_D1WAIT;
				end
				S_D1WAIT: begin
					if (div_rsp.done) begin
						rate_q  <= div_rsp.quo[CNT_W-1:0];
						state_q <= S_SCALE;
					end
				end
				S_SCALE: begin
					if (rate_q >= cap) begin
						util_q      <= PMIL_FULL;
						win_start_q <= now_q;
						tx_base_q   <= tx_q;
						rx_base_q   <= rx_q;
						closed_q    <= 1'b1;
						state_q     <= S_DONE;
					end else begin
						state_q <= S_D2GO;
					end
				end
				S_D2GO: begin
					state_q <= S_D2WAIT;
				end
				S_D2WAIT: begin
					if (div_rsp.done) begin
						util_q      <= div_rsp.quo[PMIL_W-1:0];
						win_start_q <= now_q;
						tx_base_q   <= tx_q;
						rx_base_q   <= rx_q;
						closed_q    <= 1'b1;
						state_q     <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || m_tready) begin
						out_valid_q  <= 1'b1;
						out_rate_q   <= rate_q;
						out_util_q   <= util_q;
						out_mbits_q  <= mbits;
						out_closed_q <= closed_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			now_q     <= now_in;
			tx_q      <= tx_in;
			rx_q      <= rx_in;
			elapsed_q <= elapsed;
			delta_q   <= delta;
		end
		if (state_q == S_MUL || state_q == S_SCALE) begin
			prod_q <= mul_p;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, out_mbits_q, out_util_q, out_rate_q};
	assign m_tuser  = out_closed_q;

endmodule

`default_nettype wire
